/* src/hspc_pkg.sv */
// ----------------------------------------------------------------------------
// hspc_pkg
// Shared types and codes for the high-speed pulse counter channel.
// ----------------------------------------------------------------------------
package hspc_pkg;

	localparam int CountW  = 32;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 32;

	// event codes
	localparam logic [1:0] REQ_FIRST  = 2'd0;
	localparam logic [1:0] REQ_SECOND = 2'd1;
	localparam logic [1:0] REQ_RESET  = 2'd2;

	// count modes
	localparam logic [1:0] MODE_SINGLE = 2'd0;
	localparam logic [1:0] MODE_UPDOWN = 2'd1;
	localparam logic [1:0] MODE_AB     = 2'd2;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_COUNT_MODE    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_SOFT_DOWN     = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_COMPARE_VALUE = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_COUNTER_EN    = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_RESET_IN_EN   = 3'd4;

	typedef struct packed {
		logic [1:0] req_type;
		logic       phase_a_level;
	} hspc_evt_t;

	typedef struct packed {
		logic signed [CountW-1:0] count_value;
		logic                     match_output;
		logic                     direction_down;
		logic                     compare_hit;
	} hspc_res_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [CfgDatW-1:0] wdata;
	} hspc_cfg_t;

endpackage

/* src/hspc_if.sv */
// ----------------------------------------------------------------------------
// hspc_if
// Valid/ready channels for events, results and register writes.
// ----------------------------------------------------------------------------
interface hspc_evt_if;
	logic                valid;
	logic                ready;
	hspc_pkg::hspc_evt_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hspc_res_if;
	logic                valid;
	logic                ready;
	hspc_pkg::hspc_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hspc_cfg_if;
	logic                valid;
	logic                ready;
	hspc_pkg::hspc_cfg_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/high_speed_pulse_counter_top.sv */
// ----------------------------------------------------------------------------
// high_speed_pulse_counter_top
// One counter channel: single-phase, up/down or A/B counting with compare.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  evt      in   req_type, phase_a_level
//  res      out  count_value, match_output, direction_down, compare_hit
//  cfg      in   index, wdata (always ready)
//
//  One word per cycle while the skid is empty; an accepted result goes into the
//  result register, or into the one-word skid stage while the output is stalled.
//  The counter step and 32-bit compare sit between accept and result register.
//  evt.ready drops only while the skid is full. arst_n clears counter, output
//  bit, direction, settings and valid flags, but not the result or skid words.
// ----------------------------------------------------------------------------
module high_speed_pulse_counter_top (
	input  logic           clk,
	input  logic           arst_n,
	hspc_evt_if.sink       evt,
	hspc_res_if.source     res,
	hspc_cfg_if.sink       cfg
);
	import hspc_pkg::*;

	logic [1:0]               mode_q;
	logic                     soft_down_q;
	logic signed [CountW-1:0] cmp_q;
	logic                     en_q;
	logic                     rst_en_q;

	logic signed [CountW-1:0] cnt_q;
	logic                     obit_q;
	logic                     ldir_q;

	logic                     out_vld_q;
	hspc_res_t                out_q;
	logic                     skid_vld_q;
	hspc_res_t                skid_q;

	logic                     accept;
	logic                     counts;
	logic                     down;
	logic                     clr;
	logic signed [CountW-1:0] cnt_nx;
	logic                     obit_nx;
	logic                     ldir_nx;
	logic                     hit;
	hspc_res_t                res_nx;

	assign cfg.ready = 1'b1;
	assign evt.ready = !skid_vld_q;
	assign accept    = evt.valid && evt.ready;
	assign res.valid = out_vld_q;
	assign res.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SINGLE;
			soft_down_q <= 1'b0;
			cmp_q       <= '0;
			en_q        <= 1'b0;
			rst_en_q    <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_COUNT_MODE:    mode_q      <= cfg.data.wdata[1:0];
				CFG_SOFT_DOWN:     soft_down_q <= cfg.data.wdata[0];
				CFG_COMPARE_VALUE: cmp_q       <= cfg.data.wdata[CountW-1:0];
				CFG_COUNTER_EN:    en_q        <= cfg.data.wdata[0];
				CFG_RESET_IN_EN:   rst_en_q    <= cfg.data.wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		counts = 1'b0;
		down   = 1'b0;
		clr    = 1'b0;
		case (evt.data.req_type)
			REQ_RESET: clr = rst_en_q;
			REQ_FIRST, REQ_SECOND: begin
				if (en_q) begin
					case (mode_q)
						MODE_SINGLE: begin
							counts = (evt.data.req_type == REQ_FIRST);
							down   = soft_down_q;
						end
						MODE_UPDOWN: begin
							counts = 1'b1;
							down   = (evt.data.req_type == REQ_SECOND);
						end
						MODE_AB: begin
							counts = (evt.data.req_type == REQ_SECOND);
							down   = !evt.data.phase_a_level;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		cnt_nx  = cnt_q;
		obit_nx = obit_q;
		ldir_nx = ldir_q;
		hit     = 1'b0;
		if (clr) begin
			cnt_nx  = '0;
			obit_nx = 1'b0;
		end else if (counts) begin
			cnt_nx  = down ? cnt_q - CountW'(1) : cnt_q + CountW'(1);
			ldir_nx = down;
			hit     = (cnt_nx == cmp_q);
			if (hit) begin
				obit_nx = !down;
			end
		end
		res_nx.count_value    = cnt_nx;
		res_nx.match_output   = obit_nx;
		res_nx.direction_down = (mode_q == MODE_SINGLE) ? soft_down_q : ldir_nx;
		res_nx.compare_hit    = hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			obit_q <= 1'b0;
			ldir_q <= 1'b0;
		end else if (accept) begin
			cnt_q  <= cnt_nx;
			obit_q <= obit_nx;
			ldir_q <= ldir_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (accept) begin
			if (!out_vld_q || res.ready) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (res.ready) begin
			out_vld_q  <= skid_vld_q;
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_vld_q || res.ready) begin
				out_q <= res_nx;
			end else begin
				skid_q <= res_nx;
			end
		end else if (res.ready && skid_vld_q) begin
			out_q <= skid_q;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held without an output word");

	a_hit_matches: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.compare_hit |-> res.data.count_value == cmp_q)
		else $error("compare hit reported on a count that differs from target");

	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && evt.data.req_type == REQ_RESET && rst_en_q |=> cnt_q == '0 && !obit_q)
		else $error("enabled reset edge did not clear the counter");

endmodule

/* tb/hspc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hspc_checker
// Watches the event, result and register channels of the counter channel,
// keeps its own copy of the counter state, and checks every result word
// in order against the value predicted for the oldest accepted event.
// ----------------------------------------------------------------------------
module hspc_checker import hspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	hspc_evt_if  evt,
	hspc_res_if  res,
	hspc_cfg_if  cfg,
	output int   pending,
	output int   fail_count
);

	logic [1:0]               mode_r;
	logic                     soft_down_r;
	logic signed [CountW-1:0] cmp_r;
	logic                     en_r;
	logic                     rst_en_r;

	logic signed [CountW-1:0] tally;
	logic                     out_bit;
	logic                     last_down;

	hspc_res_t                expected_q[$];
	int                       errors = 0;

	task automatic predict(input hspc_evt_t w, output hspc_res_t r);
		logic moves;
		logic down;
		moves = 1'b0;
		down  = 1'b0;
		r.compare_hit = 1'b0;
		if (w.req_type == REQ_RESET) begin
			if (rst_en_r) begin
				tally   = '0;
				out_bit = 1'b0;
			end
		end else if (w.req_type < REQ_RESET && en_r) begin
			case (mode_r)
				MODE_SINGLE: begin
					if (w.req_type == REQ_FIRST) begin
						moves = 1'b1;
						down  = soft_down_r;
					end
				end
				MODE_UPDOWN: begin
					moves = 1'b1;
					down  = (w.req_type == REQ_SECOND);
				end
				MODE_AB: begin
					if (w.req_type == REQ_SECOND) begin
						moves = 1'b1;
						down  = !w.phase_a_level;
					end
				end
				default: ;
			endcase
		end
		if (moves) begin
			tally     = down ? tally - 1 : tally + 1;
			last_down = down;
			if (tally == cmp_r) begin
				r.compare_hit = 1'b1;
				out_bit       = !down;
			end
		end
		r.count_value    = tally;
		r.match_output   = out_bit;
		r.direction_down = (mode_r == MODE_SINGLE) ? soft_down_r : last_down;
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		hspc_res_t want;
		hspc_res_t got;
		if (!arst_n) begin
			mode_r      = MODE_SINGLE;
			soft_down_r = 1'b0;
			cmp_r       = '0;
			en_r        = 1'b0;
			rst_en_r    = 1'b0;
			tally       = '0;
			out_bit     = 1'b0;
			last_down   = 1'b0;
			expected_q.delete();
			pending    <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					CFG_COUNT_MODE:    mode_r      = cfg.data.wdata[1:0];
					CFG_SOFT_DOWN:     soft_down_r = cfg.data.wdata[0];
					CFG_COMPARE_VALUE: cmp_r       = cfg.data.wdata;
					CFG_COUNTER_EN:    en_r        = cfg.data.wdata[0];
					CFG_RESET_IN_EN:   rst_en_r    = cfg.data.wdata[0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				got = res.data;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word: expected none, got count %0d",
						$time, got.count_value);
				end else begin
					want = expected_q.pop_front();
					check_field("count_value", want.count_value, got.count_value);
					check_field("match_output", want.match_output, got.match_output);
					check_field("direction_down", want.direction_down, got.direction_down);
					check_field("compare_hit", want.compare_hit, got.compare_hit);
				end
			end
			if (evt.valid && evt.ready) begin
				predict(evt.data, want);
				expected_q.push_back(want);
			end
			pending <= expected_q.size();
		end
		fail_count <= errors;
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the counter channel with a directed pass over every mode, event
// kind and corner, then with random register settings and random event
// streams under bursty input and a stalling result consumer.
// ----------------------------------------------------------------------------
module tb;
	import hspc_pkg::*;

	localparam logic [1:0] REQ_UNUSED  = 2'd3;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         RandWords   = 1150;

	typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BEAT} stall_e;

	logic clk = 1'b0;
	logic arst_n;
	int   pending;
	int   fail_count;
	int   burst_left = 6;
	int   sent = 0;

	hspc_evt_if evt_ch ();
	hspc_res_if res_ch ();
	hspc_cfg_if cfg_ch ();

	high_speed_pulse_counter_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	hspc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// result consumer, stall pattern is drawn anew for every run
	initial begin : receiver
		stall_e style;
		int     run;
		int     tick;
		res_ch.ready <= 1'b0;
		style = STALL_NONE;
		run   = 0;
		tick  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (run == 0) begin
				style = stall_e'($urandom_range(0, 3));
				run   = $urandom_range(16, 160);
			end
			run--;
			tick++;
			case (style)
				STALL_NONE:  res_ch.ready <= 1'b1;
				STALL_COIN:  res_ch.ready <= ($urandom_range(0, 1) == 1);
				STALL_HEAVY: res_ch.ready <= ($urandom_range(0, 4) == 0);
				default:     res_ch.ready <= (tick % 3 != 0);
			endcase
		end
	end

	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_word(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, wdata: val};
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// stop the event stream, let results come home, then rewrite all registers
	task automatic setting(input logic [1:0] mode, input logic down,
			input logic [31:0] cmp, input logic en, input logic rst_en);
		evt_ch.valid <= 1'b0;
		drain();
		cfg_word(CFG_COUNT_MODE, {30'd0, mode});
		cfg_word(CFG_SOFT_DOWN, {31'd0, down});
		cfg_word(CFG_COMPARE_VALUE, cmp);
		cfg_word(CFG_COUNTER_EN, {31'd0, en});
		cfg_word(CFG_RESET_IN_EN, {31'd0, rst_en});
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input logic [1:0] req, input logic a);
		evt_ch.valid <= 1'b1;
		evt_ch.data  <= '{req_type: req, phase_a_level: a};
		do @(posedge clk); while (!evt_ch.ready);
		sent++;
		burst_left--;
		if (burst_left == 0) begin
			evt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
	endtask

	function automatic logic [1:0] pick_req();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return REQ_FIRST;
		else if (r < 16)
			return REQ_SECOND;
		else if (r < 19)
			return REQ_RESET;
		return REQ_UNUSED;
	endfunction

	function automatic logic [31:0] pick_compare();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 32'(int'($urandom_range(0, 16)) - 8);
		else if (r == 7)
			return 32'h8000_0000;
		else if (r == 8)
			return 32'h7FFF_FFFF;
		return $urandom;
	endfunction

	initial begin : stimulus
		int  len;
		int  r;
		bit  paused;
		logic [1:0] mode;
		evt_ch.valid <= 1'b0;
		evt_ch.data  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		arst_n       <= 1'b0;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: nothing counts
		send_word(REQ_FIRST, 1'b1);
		// single-phase up, hit at 1
		setting(MODE_SINGLE, 1'b0, 32'd1, 1'b1, 1'b1);
		send_word(REQ_FIRST, 1'b0);
		send_word(REQ_SECOND, 1'b1);
		send_word(REQ_UNUSED, 1'b0);
		send_word(REQ_RESET, 1'b1);
		// single-phase down, wrap below zero onto compare
		setting(MODE_SINGLE, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_word(REQ_FIRST, 1'b1);
		send_word(REQ_FIRST, 1'b0);
		// up/down with the largest compare
		setting(MODE_UPDOWN, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b1);
		send_word(REQ_FIRST, 1'b0);
		send_word(REQ_SECOND, 1'b1);
		send_word(REQ_SECOND, 1'b0);
		// A/B with the smallest compare, reset input masked
		setting(MODE_AB, 1'b1, 32'h8000_0000, 1'b1, 1'b0);
		send_word(REQ_SECOND, 1'b1);
		send_word(REQ_SECOND, 1'b0);
		send_word(REQ_FIRST, 1'b1);
		send_word(REQ_RESET, 1'b0);
		send_word(REQ_UNUSED, 1'b1);
		// unused mode
		setting(MODE_UNUSED, 1'b1, 32'hFFFF_FFFE, 1'b1, 1'b1);
		send_word(REQ_FIRST, 1'b0);
		send_word(REQ_SECOND, 1'b1);
		// counter stopped
		setting(MODE_UPDOWN, 1'b0, 32'hFFFF_FFFE, 1'b0, 1'b1);
		send_word(REQ_SECOND, 1'b0);
		send_word(REQ_RESET, 1'b1);

		sent = 0;
		while (sent < RandWords) begin
			r = $urandom_range(0, 19);
			mode = (r == 19) ? MODE_UNUSED : 2'(r % 3);
			setting(mode, 1'($urandom_range(0, 1)), pick_compare(),
				($urandom_range(0, 9) != 0), 1'($urandom_range(0, 1)));
			len = $urandom_range(40, 140);
			for (int i = 0; i < len; i++) begin
				if (!paused && i == len / 2) begin
					evt_ch.valid <= 1'b0;
					drain();
					paused = 1'b1;
				end
				send_word(pick_req(), 1'($urandom_range(0, 1)));
			end
		end

		evt_ch.valid <= 1'b0;
		drain();
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
